// File: hdl/atri_pkg.sv
// Shared types, constants and the quarter-wave sine generator for the triangle oscillator.
package atri_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int AMP_W     = 16;
    localparam int PHASE_W   = 32;
    localparam int MAG_W     = 23;   // Q23 sine magnitude
    localparam int HSQ_W     = 14;   // h*h for h up to 127
    localparam int RECIP_W   = 24;   // floor(2^23 / h^2), 2^23 at h = 1
    localparam int PROD_W    = 64;
    localparam int OPND_W    = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 8'd1;

    localparam logic [AMP_W-1:0]   AMPLITUDE_RESET  = 16'd16384;
    localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd9739155;

    localparam int SAMPLE_MAX = 8388607;
    localparam int SAMPLE_MIN = -8388608;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Operand pair for the shared multiplier
    typedef struct packed {
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
    } atri_mul_op_t;

    // Q23 magnitude of sin(pi/2 * k / 2^(tbits-2)), Taylor series to x^13 in Q30.
    // Evaluated at elaboration only.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k,
                                                      input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] r;
        longint      acc;
        x    = (HALF_PI_Q30 * 64'(k)) >> (tbits - 2);
        x2   = (x * x) >> 30;
        acc  = longint'(x);
        term = ((x * x2) >> 30) / 64'd6;
        acc  = acc - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        acc  = acc + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        acc  = acc - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        acc  = acc + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        acc  = acc - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        acc  = acc + longint'(term);
        if (acc < 0)
        begin
            acc = 0;
        end
        r = (64'(acc) + 64'd64) >> 7;
        if (r > 64'd8388607)
        begin
            r = 64'd8388607;
        end
        return r[MAG_W-1:0];
    endfunction

endpackage

// File: hdl/atri_if.sv
// Valid/ready channel interfaces for tick requests, samples and register writes.
interface atri_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface atri_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [atri_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface atri_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [atri_pkg::CFG_IDX_W-1:0]  index;
    logic [atri_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/additive_triangle_oscillator.sv
// Top level: additive triangle-wave oscillator with sequencer and shared multiplier.
//
// Usage
//   tick_chan   : request channel. A transfer with tick = 1 starts one sample;
//                 a transfer with tick = 0 is consumed and does nothing.
//   sample_chan : signed 24-bit samples, one per tick = 1 request, in order.
//   cfg_chan    : register writes, index 0 = amplitude (Q0.16), index 1 =
//                 phase_step. Other indexes are dropped. Always ready; write
//                 only while no sample is in progress.
// Timing
//   Each odd harmonic goes through the sequencer in turn: one sine ROM read,
//   then four passes through the single 32x32 multiplier (gain, two halves of
//   the reciprocal multiply, remainder check) plus estimate and accumulate.
//   The N = HARMONIC_LIMIT/2 harmonics are summed, saturated and registered
//   to sample_chan; a new request is taken only once the sequencer is idle
//   again, not while a sample is in progress. The output register frees the
//   sequencer for the next request; if it is still full when a sample finishes,
//   the sample waits in the sequencer and tick_chan.ready stays low.
// Reset: phase cleared, amplitude 16384, phase_step 9739155, nothing pending.
module additive_triangle_oscillator #(
    parameter int HARMONIC_LIMIT  = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    atri_tick_if.sink      tick_chan,
    atri_sample_if.source  sample_chan,
    atri_cfg_if.sink       cfg_chan
);

    localparam int NUM_HARM  = HARMONIC_LIMIT / 2;
    localparam int HIDX_W    = (NUM_HARM > 1) ? $clog2(NUM_HARM) : 1;
    localparam int SUM_W     = atri_pkg::SAMPLE_W + $clog2(NUM_HARM) + 1;
    localparam int ROM_IDX_W = SINE_TABLE_BITS - 1;
    localparam int QS        = 1 << (SINE_TABLE_BITS - 2);
    localparam int X_W       = atri_pkg::AMP_W + atri_pkg::MAG_W;   // 39
    localparam int XL_W      = 20;                                  // low split of x
    localparam int HI_W      = X_W - XL_W + atri_pkg::RECIP_W;      // 43
    localparam int REM_W     = X_W + 1;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(atri_pkg::SAMPLE_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(atri_pkg::SAMPLE_MIN);

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ROM  = 4'd1;   // sine lookup, advance harmonic phase
    localparam logic [3:0] ST_MAMP = 4'd2;   // amplitude * |sin|
    localparam logic [3:0] ST_MHI  = 4'd3;   // x[38:20] * recip
    localparam logic [3:0] ST_MLO  = 4'd4;   // x[19:0] * recip
    localparam logic [3:0] ST_EST  = 4'd5;   // quotient estimate
    localparam logic [3:0] ST_MCHK = 4'd6;   // estimate * h^2
    localparam logic [3:0] ST_ACC  = 4'd7;   // correct, sign, accumulate
    localparam logic [3:0] ST_DONE = 4'd8;   // saturate, hand to output

    // per-harmonic constants
    logic [atri_pkg::HSQ_W-1:0]   hsq_tab   [NUM_HARM];
    logic [atri_pkg::RECIP_W-1:0] recip_tab [NUM_HARM];

    for (genvar gj = 0; gj < NUM_HARM; gj++)
    begin : g_harm
        localparam int unsigned H   = 2 * gj + 1;
        localparam int unsigned HSQ = H * H;
        localparam int unsigned RCP = (32'd1 << 23) / HSQ;
        assign hsq_tab[gj]   = atri_pkg::HSQ_W'(HSQ);
        assign recip_tab[gj] = atri_pkg::RECIP_W'(RCP);
    end

    logic [3:0]                      state_reg,      state_next;
    logic [atri_pkg::AMP_W-1:0]      amp_reg;
    logic [atri_pkg::PHASE_W-1:0]    step_reg;
    logic [atri_pkg::PHASE_W-1:0]    base_phase_reg, base_phase_next;
    logic [atri_pkg::PHASE_W-1:0]    hphase_reg,     hphase_next;
    logic [HIDX_W-1:0]               harm_reg,       harm_next;
    logic                            neg_reg,        neg_next;
    logic [X_W-1:0]                  x_reg,          x_next;
    logic [HI_W-1:0]                 hi_reg,         hi_next;
    logic [atri_pkg::RECIP_W-1:0]    est_reg,        est_next;
    logic signed [SUM_W-1:0]         sum_reg,        sum_next;
    logic signed [atri_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic                            out_valid_reg,  out_valid_next;

    logic                            tick_go;
    logic                            out_free;
    logic [ROM_IDX_W-1:0]            rom_idx;
    logic [SINE_TABLE_BITS-3:0]      rom_raw;
    logic [atri_pkg::MAG_W-1:0]      mag;
    atri_pkg::atri_mul_op_t          mul_op;
    logic [atri_pkg::PROD_W-1:0]     prod;
    logic [atri_pkg::PROD_W-1:0]     est_sum;
    logic [REM_W-1:0]                rem;
    logic                            bump;
    logic [atri_pkg::RECIP_W-1:0]    term;
    logic signed [SUM_W-1:0]         term_ext;
    logic signed [SUM_W-1:0]         sat;

    assign tick_chan.ready   = (state_reg == ST_IDLE);
    assign tick_go           = tick_chan.valid && tick_chan.ready && tick_chan.tick;
    assign cfg_chan.ready    = 1'b1;
    assign sample_chan.valid = out_valid_reg;
    assign sample_chan.sample = sample_reg;
    assign out_free          = !out_valid_reg || sample_chan.ready;

    // quarter-wave addressing: odd quadrants mirror, upper half negates
    assign rom_raw = hphase_reg[29 -: (SINE_TABLE_BITS - 2)];
    always_comb
    begin
        if (hphase_reg[30])
        begin
            rom_idx = ROM_IDX_W'(QS) - {1'b0, rom_raw};
        end
        else
        begin
            rom_idx = {1'b0, rom_raw};
        end
    end

    atri_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk      (clk),
        .en       (state_reg == ST_ROM),
        .addr     (rom_idx),
        .data_reg (mag)
    );

    atri_mul u_mul (
        .clk      (clk),
        .op       (mul_op),
        .prod_reg (prod)
    );

    // reciprocal estimate is floor or one below floor of x / (h^2 * 2^16)
    assign est_sum  = {1'b0, hi_reg, {XL_W{1'b0}}} + prod;
    assign rem      = {1'b0, x_reg} - {prod[atri_pkg::RECIP_W-1:0], 16'b0};
    assign bump     = rem >= REM_W'({hsq_tab[harm_reg], 16'b0});
    assign term     = est_reg + atri_pkg::RECIP_W'(bump);
    assign term_ext = {{(SUM_W - atri_pkg::RECIP_W){1'b0}}, term};

    always_comb
    begin
        if (sum_reg > SAT_HI)
        begin
            sat = SAT_HI;
        end
        else if (sum_reg < SAT_LO)
        begin
            sat = SAT_LO;
        end
        else
        begin
            sat = sum_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        base_phase_next = base_phase_reg;
        hphase_next     = hphase_reg;
        harm_next       = harm_reg;
        neg_next        = neg_reg;
        x_next          = x_reg;
        hi_next         = hi_reg;
        est_next        = est_reg;
        sum_next        = sum_reg;
        sample_next     = sample_reg;
        out_valid_next  = out_valid_reg;
        mul_op          = '0;

        if (sample_chan.valid && sample_chan.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (tick_go)
                begin
                    hphase_next = base_phase_reg;
                    harm_next   = '0;
                    sum_next    = '0;
                    state_next  = ST_ROM;
                end
            end
            ST_ROM:
            begin
                // triangle sign alternates every other odd harmonic
                neg_next    = hphase_reg[31] ^ harm_reg[0];
                hphase_next = hphase_reg + {base_phase_reg[30:0], 1'b0};
                state_next  = ST_MAMP;
            end
            ST_MAMP:
            begin
                mul_op.a   = atri_pkg::OPND_W'(amp_reg);
                mul_op.b   = atri_pkg::OPND_W'(mag);
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                x_next     = prod[X_W-1:0];
                mul_op.a   = atri_pkg::OPND_W'(prod[X_W-1:XL_W]);
                mul_op.b   = atri_pkg::OPND_W'(recip_tab[harm_reg]);
                state_next = ST_MLO;
            end
            ST_MLO:
            begin
                hi_next    = prod[HI_W-1:0];
                mul_op.a   = atri_pkg::OPND_W'(x_reg[XL_W-1:0]);
                mul_op.b   = atri_pkg::OPND_W'(recip_tab[harm_reg]);
                state_next = ST_EST;
            end
            ST_EST:
            begin
                est_next   = est_sum[62:39];
                state_next = ST_MCHK;
            end
            ST_MCHK:
            begin
                mul_op.a   = atri_pkg::OPND_W'(est_reg);
                mul_op.b   = atri_pkg::OPND_W'(hsq_tab[harm_reg]);
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                sum_next = neg_reg ? (sum_reg - term_ext) : (sum_reg + term_ext);
                if (harm_reg == HIDX_W'(NUM_HARM - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    harm_next  = harm_reg + 1'b1;
                    state_next = ST_ROM;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    sample_next     = sat[atri_pkg::SAMPLE_W-1:0];
                    out_valid_next  = 1'b1;
                    base_phase_next = base_phase_reg + step_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            base_phase_reg <= '0;
            out_valid_reg  <= 1'b0;
            amp_reg        <= atri_pkg::AMPLITUDE_RESET;
            step_reg       <= atri_pkg::PHASE_STEP_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            base_phase_reg <= base_phase_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_chan.valid && cfg_chan.ready)
            begin
                case (cfg_chan.index)
                    atri_pkg::REG_AMPLITUDE:  amp_reg  <= cfg_chan.data[atri_pkg::AMP_W-1:0];
                    atri_pkg::REG_PHASE_STEP: step_reg <= cfg_chan.data;
                    default:                  ;
                endcase
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        hphase_reg <= hphase_next;
        harm_reg   <= harm_next;
        neg_reg    <= neg_next;
        x_reg      <= x_next;
        hi_reg     <= hi_next;
        est_reg    <= est_next;
        sum_reg    <= sum_next;
        sample_reg <= sample_next;
    end

endmodule

// File: hdl/atri_sine_rom.sv
// Quarter-wave sine ROM with registered read.
module atri_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [TABLE_BITS-2:0]         addr,
    output logic [atri_pkg::MAG_W-1:0]    data_reg
);

    localparam int QS = 1 << (TABLE_BITS - 2);

    logic [atri_pkg::MAG_W-1:0] rom [0:QS];

    for (genvar gk = 0; gk <= QS; gk++)
    begin : g_entry
        localparam logic [atri_pkg::MAG_W-1:0] V = atri_pkg::quarter_sine(gk, TABLE_BITS);
        assign rom[gk] = V;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= rom[addr];
        end
    end

endmodule

// File: hdl/atri_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
module atri_mul (
    input  logic                          clk,
    input  atri_pkg::atri_mul_op_t        op,
    output logic [atri_pkg::PROD_W-1:0]   prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= atri_pkg::PROD_W'(op.a) * atri_pkg::PROD_W'(op.b);
    end

endmodule

// File: hdl/atri_checker.sv
// Port-level checker for the triangle oscillator and its bind.
module atri_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 tick_valid,
    input logic                                 tick_ready,
    input logic                                 tick,
    input logic                                 sample_valid,
    input logic                                 sample_ready,
    input logic signed [atri_pkg::SAMPLE_W-1:0] sample,
    input logic                                 cfg_ready
);

    // a stalled sample holds
    a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=> sample_valid && $stable(sample))
        else $error("sample dropped or changed while stalled");

    // a real tick makes the block busy
    a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready && tick |=> !tick_ready)
        else $error("ready after tick transfer");

    // an empty tick leaves the block idle
    a_idle_after_empty: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready && !tick |=> tick_ready)
        else $error("busy after empty tick");

    // a new sample only comes out of a busy sequencer
    a_sample_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_valid) |-> $past(!tick_ready))
        else $error("sample appeared while idle");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port stalled");

endmodule

bind additive_triangle_oscillator atri_checker u_atri_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_valid   (tick_chan.valid),
    .tick_ready   (tick_chan.ready),
    .tick         (tick_chan.tick),
    .sample_valid (sample_chan.valid),
    .sample_ready (sample_chan.ready),
    .sample       (sample_chan.sample),
    .cfg_ready    (cfg_chan.ready)
);

// File: bench/tb.sv
// Self-checking testbench for the additive triangle-wave oscillator.
module tb;

    // Block configuration under test; must match the instance below.
    localparam int HARMONICS  = 32;
    localparam int TABLE_BITS = 10;
    localparam int QUARTER    = 1 << (TABLE_BITS - 2);

    // Time for one sample through the sequencer over every harmonic, plus padding.
    localparam int SETTLE_CYCLES = 7 * (HARMONICS / 2) + 8;
    localparam int RX_HOLD_LEN   = 700;     // long receiver hold-off, in cycles
    localparam int LIMIT_CYCLES  = 400000;  // watchdog
    localparam int PHASE_ITEMS   = 84;      // tick = 1 requests per random phase
    localparam int RANDOM_PHASES = 6;

    // Indexes the block must drop.
    localparam logic [atri_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd2;
    localparam logic [atri_pkg::CFG_IDX_W-1:0] REG_LAST  = 8'hFF;

    // Predicts every sample from the register state and the phase it tracks,
    // and holds the predictions until the block delivers them, in order.
    class sample_scoreboard;
        bit [atri_pkg::MAG_W-1:0]             sine_q23 [QUARTER+1];
        bit [atri_pkg::AMP_W-1:0]             gain;
        bit [atri_pkg::PHASE_W-1:0]           step;
        bit [atri_pkg::PHASE_W-1:0]           acc_phase;
        logic signed [atri_pkg::SAMPLE_W-1:0] pending_samples [$];
        int                                   n_checked;
        int                                   n_clipped;

        function new();
            bit [63:0] x;
            bit [63:0] x2;
            bit [63:0] term;
            bit [63:0] r;
            longint    acc;
            // Quarter-wave table: Taylor series to x^13 in Q30, rounded to Q23.
            for (int k = 0; k <= QUARTER; k++)
            begin
                x    = (atri_pkg::HALF_PI_Q30 * 64'(k)) >> (TABLE_BITS - 2);
                x2   = (x * x) >> 30;
                term = x;
                acc  = longint'(x);
                for (int n = 1; n <= 6; n++)
                begin
                    term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1)
                        acc = acc - longint'(term);
                    else
                        acc = acc + longint'(term);
                end
                if (acc < 0)
                    acc = 0;
                r = (64'(acc) + 64'd64) >> 7;
                if (r > 64'(atri_pkg::SAMPLE_MAX))
                    r = 64'(atri_pkg::SAMPLE_MAX);
                sine_q23[k] = r[atri_pkg::MAG_W-1:0];
            end
            gain      = atri_pkg::AMPLITUDE_RESET;
            step      = atri_pkg::PHASE_STEP_RESET;
            acc_phase = '0;
            n_checked = 0;
            n_clipped = 0;
        endfunction

        function void load_reg(logic [atri_pkg::CFG_IDX_W-1:0] idx,
                               logic [atri_pkg::CFG_DAT_W-1:0] data);
            case (idx)
                atri_pkg::REG_AMPLITUDE:  gain = data[atri_pkg::AMP_W-1:0];
                atri_pkg::REG_PHASE_STEP: step = data[atri_pkg::PHASE_W-1:0];
                default: ;
            endcase
        endfunction

        // A tick = 1 request: sum the odd harmonics, clip, advance the phase.
        function void note_request();
            longint                     total;
            bit [63:0]                  wide;
            bit [atri_pkg::PHASE_W-1:0] p;
            bit [1:0]                   quad;
            int unsigned                idx;
            bit [63:0]                  t;
            bit                         neg;
            total = 0;
            for (int h = 1; h < HARMONICS; h += 2)
            begin
                wide = 64'(acc_phase) * 64'(h);
                p    = wide[atri_pkg::PHASE_W-1:0];
                quad = p[31:30];
                idx  = (p >> (32 - TABLE_BITS)) & (QUARTER - 1);
                if (quad[0])
                    idx = QUARTER - idx;
                neg = quad[1];
                t   = ((64'(gain) * 64'(sine_q23[idx])) / 64'(h * h)) >> 16;
                // triangle series alternates sign every other odd harmonic
                if (((h - 1) >> 1) % 2 == 1)
                    neg = !neg;
                total = neg ? total - longint'(t) : total + longint'(t);
            end
            if (total > atri_pkg::SAMPLE_MAX || total < atri_pkg::SAMPLE_MIN)
                n_clipped++;
            if (total > atri_pkg::SAMPLE_MAX)
                total = atri_pkg::SAMPLE_MAX;
            if (total < atri_pkg::SAMPLE_MIN)
                total = atri_pkg::SAMPLE_MIN;
            pending_samples.push_back(total[atri_pkg::SAMPLE_W-1:0]);
            acc_phase = acc_phase + step;
        endfunction

        function bit check_sample(logic signed [atri_pkg::SAMPLE_W-1:0] got,
                                  output string why);
            logic signed [atri_pkg::SAMPLE_W-1:0] want;
            why = "";
            if (pending_samples.size() == 0)
            begin
                why = $sformatf("sample %0d arrived with nothing outstanding", got);
                return 1'b0;
            end
            want = pending_samples.pop_front();
            n_checked++;
            if (got !== want)
            begin
                why = $sformatf("sample #%0d: got %0d, want %0d", n_checked, got, want);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function int pending();
            return pending_samples.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    atri_tick_if   tick_ch ();
    atri_sample_if sample_ch ();
    atri_cfg_if    cfg_ch ();

    additive_triangle_oscillator #(
        .HARMONIC_LIMIT  (HARMONICS),
        .SINE_TABLE_BITS (TABLE_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_chan   (tick_ch),
        .sample_chan (sample_ch),
        .cfg_chan    (cfg_ch)
    );

    sample_scoreboard sb = new();

    int error_count   = 0;
    int cycle_count   = 0;
    int n_requests    = 0;
    int n_idle_reqs   = 0;     // tick = 0 transfers
    int n_cfg_writes  = 0;
    int tx_idle_pct   = 0;     // chance per cycle that the tick side holds back
    int rx_idle_pct   = 0;     // chance per cycle that the sample side stalls
    int hold_requests = 0;     // bumped by the main flow, served by the receiver

    // 2-unit clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d samples still outstanding",
                     cycle_count, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string why);
        error_count++;
        $display("MISMATCH @%0d: %s", cycle_count, why);
    endtask

    // Monitor: every transfer is observed at the rising edge, before the
    // block's own updates land, so ordering within the step does not matter.
    always @(posedge clk)
    begin
        string why;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                n_cfg_writes++;
                sb.load_reg(cfg_ch.index, cfg_ch.data);
            end
            if (tick_ch.valid && tick_ch.ready)
            begin
                n_requests++;
                if (tick_ch.tick)
                    sb.note_request();
                else
                    n_idle_reqs++;
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                if (!sb.check_sample(sample_ch.sample, why))
                    report_mismatch(why);
            end
        end
    end

    // Sample side: random stalls, plus a long hold-off whenever the main
    // flow asks for one; the hold is counted here, cycle by cycle.
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left       = 0;
        holds_done      = 0;
        sample_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_done < hold_requests)
            begin
                hold_left = RX_HOLD_LEN;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                sample_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                sample_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // One request transfer. Valid stays up on return so back-to-back
    // requests need no drop; park_ticks, or an idle spell in the next call, lowers it.
    task automatic send_tick(input bit t);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            tick_ch.tick  <= 1'($urandom_range(1));
            @(negedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.tick  <= t;
        do
            @(posedge clk);
        while (!tick_ch.ready);
    endtask

    // Drop valid, let every predicted sample come back, then give the
    // sequencer a full sample time to settle.
    task automatic park_ticks();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [atri_pkg::CFG_IDX_W-1:0] idx,
                             input logic [atri_pkg::CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_tick(1'b1);
    endtask

    // Main flow
    initial
    begin
        int sent;
        bit t;
        logic [atri_pkg::AMP_W-1:0]   amp;
        logic [atri_pkg::PHASE_W-1:0] stp;

        rst_n         = 1'b0;
        tick_ch.valid = 1'b0;
        tick_ch.tick  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- Directed part ----
        // Reset settings; the tick = 0 requests in between must not move the phase.
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        park_ticks();

        // Full gain, upper data bits set (must be masked off). Land the phase
        // on zero, then walk it in quarter cycles: peaks clip on both rails,
        // and the fourth step wraps the accumulator.
        cfg_write(atri_pkg::REG_AMPLITUDE, 32'hFFFF_FFFF);
        cfg_write(atri_pkg::REG_PHASE_STEP, 32'(0) - sb.acc_phase);
        send_ticks(1);
        park_ticks();
        cfg_write(atri_pkg::REG_PHASE_STEP, 32'h4000_0000);
        send_ticks(5);
        park_ticks();

        // Unknown indexes are dropped: settings stay as they were.
        cfg_write(REG_SPARE, 32'h0000_0000);
        cfg_write(REG_LAST, 32'hFFFF_FFFF);
        send_ticks(2);
        park_ticks();

        // Zero gain (data upper half nonzero), all-ones step: phase wraps every sample.
        cfg_write(atri_pkg::REG_AMPLITUDE, 32'hABCD_0000);
        cfg_write(atri_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
        send_ticks(3);
        park_ticks();

        cfg_write(atri_pkg::REG_AMPLITUDE, 32'h0000_FFFF);
        send_ticks(3);
        park_ticks();

        // ---- Random part ----
        // Phases 0-1: sender idles lightly, receiver heavily; 2-3 reversed;
        // 4-5 no idling, and phase 4 opens with a long receiver hold-off so
        // the output register and sequencer fill and tick_chan backs up.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    amp = 16'($urandom_range(65535));
                    stp = $urandom;
                end
                1:
                begin
                    amp = 16'hFFFF;
                    stp = $urandom;
                end
                2:
                begin
                    amp = 16'($urandom_range(65535));
                    stp = $urandom_range(1 << 20);
                end
                3:
                begin
                    amp = 16'($urandom_range(65535));
                    stp = 32'hFFFF_FFFF - $urandom_range(1 << 20);
                end
                4:
                begin
                    amp = 16'hFFFF;
                    stp = $urandom;
                end
                default:
                begin
                    amp = atri_pkg::AMPLITUDE_RESET;
                    stp = atri_pkg::PHASE_STEP_RESET;
                end
            endcase
            cfg_write(atri_pkg::REG_AMPLITUDE, {16'($urandom_range(65535)), amp});
            cfg_write(atri_pkg::REG_PHASE_STEP, stp);

            if (ph < 2)
            begin
                tx_idle_pct = 17;
                rx_idle_pct = 49;
            end
            else if (ph < 4)
            begin
                tx_idle_pct = 49;
                rx_idle_pct = 17;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (ph == 4)
                hold_requests++;

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                t = ($urandom_range(7) != 0);
                send_tick(t);
                if (t)
                    sent++;
            end
            park_ticks();
        end

        if (sb.pending() != 0)
            report_mismatch($sformatf("%0d samples never arrived", sb.pending()));

        $display("Checked %0d samples (%0d clipped) from %0d requests, %0d with tick low.",
                 sb.n_checked, sb.n_clipped, n_requests, n_idle_reqs);
        $display("%0d register writes (zero/full gain, bad indexes), %0d-cycle output stall.",
                 n_cfg_writes, RX_HOLD_LEN);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("%0d mismatches", error_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: additive_triangle_oscillator.f
hdl/atri_pkg.sv
hdl/atri_if.sv
hdl/atri_sine_rom.sv
hdl/atri_mul.sv
hdl/additive_triangle_oscillator.sv
hdl/atri_checker.sv
bench/tb.sv
